// ===== hw/rtl/ttne_pkg.sv =====
// Package for the timer table with next-event tracking.
// Holds widths, opcode and status codes, and controller/datapath link structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ttne_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int TICK_W        = 16;
  localparam int ID_W          = 8;
  localparam int MSG_W         = 8;
  localparam int OP_W          = 3;
  localparam int ST_W          = 3;
  localparam int CNT_W         = 7;
  localparam int SLOT_W        = 2 * TICK_W + MSG_W;
  localparam logic [TICK_W-1:0] DIST_INIT = 16'hFFFF;
  localparam logic [CNT_W-1:0]  CNT_MAX   = 7'h7F;

  localparam logic [OP_W-1:0] OP_SET    = 3'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 3'd1;
  localparam logic [OP_W-1:0] OP_CLRALL = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_IN_USE   = 3'd1;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [ST_W-1:0] ST_BAD_DLY  = 3'd3;
  localparam logic [ST_W-1:0] ST_MISMATCH = 3'd4;

  typedef struct packed {
    logic capture;
    logic exec;
    logic ccmp;
    logic scan_rd;
    logic chk_step;
    logic load_out;
  } ttne_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            cancel_hit;
    logic            rescan;
    logic            idx_last;
    logic            out_busy;
  } ttne_sts_t;

  function automatic int ttne_idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ttne_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ttne_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                    wdata,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output      logic [W-1:0]                    rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/ttne_ctrl.sv =====
// Sequencer for the timer table: decode, cancel compare, rescan and recount.
// Depends on ttne_pkg; drives the datapath through ttne_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module ttne_ctrl
  import ttne_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output      logic      in_tready,
  input  wire ttne_sts_t sts,
  output      ttne_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_CCMP  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SLAST = 3'd4;
  localparam logic [2:0] S_CHK   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.cancel_hit) begin
          state_nxt = S_CCMP;
        end else if (sts.op == OP_CHECK) begin
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CCMP: begin
        cmd.ccmp  = 1'b1;
        state_nxt = sts.rescan ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.idx_last) state_nxt = S_SLAST;
      end
      S_SLAST: begin
        state_nxt = S_DONE;
      end
      S_CHK: begin
        cmd.chk_step = 1'b1;
        if (sts.idx_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.idx_last) |=> (state_r == S_SLAST))
    else $error("scan did not hand over to final compare");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == S_IDLE))
    else $error("ready raised outside idle");
  a_cancel_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && sts.cancel_hit) |=> (state_r == S_CCMP))
    else $error("cancel hit skipped the compare step");

endmodule
`default_nettype wire

// ===== hw/rtl/ttne_dp.sv =====
// Datapath for the timer table: slot flags, slot RAM, count, earliest expiry,
// rescan and recount units, and the output register. Depends on ttne_pkg, ttne_ram.
`timescale 1ns / 1ps
`default_nettype none
module ttne_dp
  import ttne_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ttne_cmd_t         cmd,
  output      ttne_sts_t         sts,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [ID_W-1:0]   in_id,
  input  wire logic [TICK_W-1:0] in_dly,
  input  wire logic [TICK_W-1:0] in_rel,
  input  wire logic [MSG_W-1:0]  in_msg,
  input  wire logic [TICK_W-1:0] in_now,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [ST_W-1:0]   out_status,
  output      logic              out_act,
  output      logic [TICK_W-1:0] out_next,
  output      logic [CNT_W-1:0]  out_total
);

  localparam int IW = ttne_idx_w(NUM_SLOTS);

  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   id_r;
  logic [TICK_W-1:0] dly_r, now_r;
  logic [TICK_W-1:0] rel_r;
  logic [MSG_W-1:0]  msg_r;

  logic [NUM_SLOTS-1:0] flags_r, flags_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TICK_W-1:0]    early_r, early_nxt;
  logic [ST_W-1:0]      st_r, st_nxt;
  logic [IW-1:0]        idx_r, idx_nxt, idxd_r;
  logic                 pv_r;
  logic [TICK_W-1:0]    best_r, best_nxt;
  logic [CNT_W-1:0]     pop_r, pop_nxt;

  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic              out_act_r;
  logic [TICK_W-1:0] out_next_r;
  logic [CNT_W-1:0]  out_total_r;

  logic              id_ok;
  logic [IW-1:0]     id_idx;
  logic              flag_id;
  logic [TICK_W-1:0] exp_new;
  logic              ram_we;
  logic [IW-1:0]     ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;
  logic [TICK_W-1:0] rexp;
  logic [TICK_W-1:0] rdist;
  logic [CNT_W-1:0]  cnt_dec;

  assign id_ok   = id_r < ID_W'(NUM_SLOTS);
  assign id_idx  = id_r[IW-1:0];
  assign flag_id = id_ok && flags_r[id_idx];
  assign exp_new = now_r + dly_r;
  assign rexp    = ram_rdata[TICK_W-1:0];
  assign rdist   = rexp - now_r;
  assign cnt_dec = (cnt_r == '0) ? '0 : cnt_r - CNT_W'(1);

  assign ram_we    = cmd.exec && op_r == OP_SET && id_ok && dly_r != '0 && !flag_id;
  assign ram_raddr = cmd.scan_rd ? idx_r : id_idx;

  ttne_ram #(
    .W (SLOT_W),
    .D (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (id_idx),
    .wdata ({msg_r, rel_r, exp_new}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.op         = op_r;
    sts.cancel_hit = op_r == OP_CANCEL && flag_id;
    sts.rescan     = cnt_dec != '0 && rexp == early_r;
    sts.idx_last   = idx_r == IW'(NUM_SLOTS - 1);
    sts.out_busy   = out_valid_r && !out_ready;
  end

  always_comb begin
    flags_nxt = flags_r;
    cnt_nxt   = cnt_r;
    early_nxt = early_r;
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    best_nxt  = best_r;
    pop_nxt   = pop_r;

    if (cmd.exec) begin
      st_nxt  = ST_OK;
      idx_nxt = '0;
      pop_nxt = '0;
      case (op_r)
        OP_SET: begin
          if (!id_ok) begin
            st_nxt = ST_RANGE;
          end else if (dly_r == '0) begin
            st_nxt = ST_BAD_DLY;
          end else if (flag_id) begin
            st_nxt = ST_IN_USE;
          end else begin
            flags_nxt[id_idx] = 1'b1;
            if (cnt_r == '0 || dly_r < (early_r - now_r)) early_nxt = exp_new;
            if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        OP_CANCEL: begin
          if (!id_ok) st_nxt = ST_RANGE;
        end
        OP_CLRALL: begin
          flags_nxt = '0;
          cnt_nxt   = '0;
        end
        OP_QUERY: begin
          if (!id_ok) st_nxt = ST_RANGE;
        end
        default: ;
      endcase
    end

    if (cmd.ccmp) begin
      flags_nxt[id_idx] = 1'b0;
      cnt_nxt           = cnt_dec;
      idx_nxt           = '0;
      best_nxt          = DIST_INIT;
    end

    if (cmd.scan_rd) begin
      idx_nxt = idx_r + IW'(1);
    end

    if (pv_r && flags_r[idxd_r] && rdist < best_r) begin
      best_nxt  = rdist;
      early_nxt = rexp;
    end

    if (cmd.chk_step) begin
      pop_nxt = pop_r + CNT_W'(flags_r[idx_r]);
      idx_nxt = idx_r + IW'(1);
      if (sts.idx_last) begin
        st_nxt = (pop_nxt != cnt_r) ? ST_MISMATCH : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      id_r  <= in_id;
      dly_r <= in_dly;
      rel_r <= in_rel;
      msg_r <= in_msg;
      now_r <= in_now;
    end
    st_r   <= st_nxt;
    idx_r  <= idx_nxt;
    idxd_r <= idx_r;
    best_r <= best_nxt;
    pop_r  <= pop_nxt;
    if (cmd.load_out) begin
      out_status_r <= st_r;
      out_act_r    <= flag_id;
      out_next_r   <= early_r;
      out_total_r  <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      cnt_r       <= '0;
      early_r     <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      flags_r <= flags_nxt;
      cnt_r   <= cnt_nxt;
      early_r <= early_nxt;
      pv_r    <= cmd.scan_rd;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_act    = out_act_r;
  assign out_next   = out_next_r;
  assign out_total  = out_total_r;

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(flags_r) == 32'(cnt_r))
    else $error("active count differs from set flags");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_SLOTS))
    else $error("active count above slot count");
  a_cancel_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ccmp |=> !flags_r[id_idx])
    else $error("cancelled slot still active");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_ready))
    else $error("result overwritten before taken");

endmodule
`default_nettype wire

// ===== hw/rtl/timer_table_next_event.sv =====
// Top level of the timer table with next-event tracking.
// Depends on ttne_pkg, ttne_ctrl, ttne_dp (and ttne_ram through ttne_dp).
//
//  channel | ports      | tuser          | tdata
//  in      | in_t*      | [2:0] opcode   | slot_id, delay_ticks, reload_period,
//          |            |                | message_id, now_tick (64 bits)
//  out     | out_t*     | [2:0] status   | slot_active, next_event_time,
//          |            |                | active_total (24 bits)
//
// One word at a time: set, query, cancel-all, idle and out-of-range cancel go from accept
// through the execute step to the result; check walks the flags one per cycle;
// a cancel of the earliest timer with others still armed rescans the slots, one
// registered slot RAM read per cycle; any other cancel of an armed timer adds the compare step.
// A result held by out_tready stalls the next one.
// Reset clears all flags, the count and the earliest expiry; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module timer_table_next_event
  import ttne_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [63:0] in_tdata,   // slot_id, delay_ticks, reload_period, message_id, now_tick
  input  wire logic [2:0]  in_tuser,   // opcode
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [23:0] out_tdata,  // slot_active, next_event_time, active_total
  output      logic [2:0]  out_tuser   // status
);

  ttne_cmd_t         cmd;
  ttne_sts_t         sts;
  logic              out_act;
  logic [TICK_W-1:0] out_next;
  logic [CNT_W-1:0]  out_total;

  ttne_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttne_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_id      (in_tdata[7:0]),
    .in_dly     (in_tdata[23:8]),
    .in_rel     (in_tdata[39:24]),
    .in_msg     (in_tdata[47:40]),
    .in_now     (in_tdata[63:48]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_act    (out_act),
    .out_next   (out_next),
    .out_total  (out_total)
  );

  assign out_tdata = {out_total, out_next, out_act};

endmodule
`default_nettype wire
